[src/srg_pkg.sv]
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types and constants for the stepper ramp generator: beat layouts,
// motion phase codes, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam int MICROSTEPS = 32;
    localparam int ACC_BITS   = 17;

    localparam int SPEED_W   = 17;
    localparam int MOVE_W    = 24;
    localparam int STEP_W    = 32;
    localparam int CFG_IDX_W = 2;

    // phase and speed accumulator adds, carry out of ACC_BITS
    localparam int ADD_W   = ((ACC_BITS > SPEED_W) ? ACC_BITS : SPEED_W) + 1;
    localparam int CARRY_W = ADD_W - ACC_BITS;
    // speed plus carry, wide enough to see saturation
    localparam int NS_W    = ((SPEED_W > CARRY_W) ? SPEED_W : CARRY_W) + 1;

    localparam logic [SPEED_W-1:0] SPEED_MAX       = {SPEED_W{1'b1}};
    localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 17'd90000;
    localparam logic [SPEED_W-1:0] ACCEL_RESET     = 17'd10000;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ACCEL   = 2'd1;
    localparam logic [1:0] PH_UNIFORM = 2'd2;
    localparam logic [1:0] PH_DECEL   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = 2'd1;

    typedef struct packed {
        logic                     op;
        logic signed [MOVE_W-1:0] move_steps;
    } in_t;

    typedef struct packed {
        logic       step_pulse;
        logic       dir_ccw;
        logic [1:0] phase_code;
        logic       running;
    } out_t;

endpackage

[src/srg_core.sv]
// ----------------------------------------------------------------------------
// srg_core
// Motion state and profile arithmetic. Each accepted beat updates the state
// registers and presents its result combinationally.
// ----------------------------------------------------------------------------
module srg_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_accept,
    input  srg_pkg::in_t                  item,
    input  logic                          cfg_we,
    input  logic [srg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srg_pkg::SPEED_W-1:0]   cfg_data,
    output srg_pkg::out_t                 result
);
    import srg_pkg::*;

    logic [SPEED_W-1:0]  max_speed_reg, accel_rate_reg;
    logic [SPEED_W-1:0]  lim_latch_reg, lim_latch_next;
    logic [SPEED_W-1:0]  acc_latch_reg, acc_latch_next;
    logic [ACC_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [ACC_BITS-1:0] speed_acc_reg, speed_acc_next;
    logic [SPEED_W-1:0]  cur_speed_reg, cur_speed_next;
    logic [STEP_W-1:0]   target_steps_reg, target_steps_next;
    logic [STEP_W-2:0]   half_target_reg, half_target_next;
    logic [STEP_W-1:0]   taken_steps_reg, taken_steps_next;
    logic [STEP_W-1:0]   ramp_steps_reg, ramp_steps_next;
    logic [1:0]          motion_phase_reg, motion_phase_next;
    logic                dir_reg, dir_next;
    logic                tick_en_reg, tick_en_next;

    logic [MOVE_W-1:0]  raw;
    logic [MOVE_W-1:0]  mag;
    logic [STEP_W-1:0]  target_new;
    logic [ADD_W-1:0]   phase_sum, speed_sum;
    logic [CARRY_W-1:0] phase_carry, speed_carry;
    logic [NS_W-1:0]    speed_up;
    logic [STEP_W-1:0]  taken_inc;
    logic [STEP_W-1:0]  remaining;
    logic               pulse;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg  <= MAX_SPEED_RESET;
            accel_rate_reg <= ACCEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_SPEED:  max_speed_reg  <= cfg_data;
                REG_ACCEL_RATE: accel_rate_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // start beat: magnitude of the step count, scaled to microsteps
    assign raw        = item.move_steps;
    assign mag        = raw[MOVE_W-1] ? (~raw + 1'b1) : raw;
    assign target_new = STEP_W'(STEP_W'(mag) * STEP_W'(MICROSTEPS));

    // tick arithmetic
    assign phase_sum   = ADD_W'(phase_acc_reg) + ADD_W'(cur_speed_reg);
    assign phase_carry = phase_sum[ADD_W-1:ACC_BITS];
    assign speed_sum   = ADD_W'(speed_acc_reg) + ADD_W'(acc_latch_reg);
    assign speed_carry = speed_sum[ADD_W-1:ACC_BITS];
    assign speed_up    = NS_W'(cur_speed_reg) + NS_W'(speed_carry);
    assign pulse       = (phase_carry != '0);
    assign taken_inc   = taken_steps_reg + STEP_W'(pulse);
    // steps left after this tick's pulse is counted
    assign remaining   = target_steps_reg - taken_inc;

    always_comb
    begin
        lim_latch_next    = lim_latch_reg;
        acc_latch_next    = acc_latch_reg;
        phase_acc_next    = phase_acc_reg;
        speed_acc_next    = speed_acc_reg;
        cur_speed_next    = cur_speed_reg;
        target_steps_next = target_steps_reg;
        half_target_next  = half_target_reg;
        taken_steps_next  = taken_steps_reg;
        ramp_steps_next   = ramp_steps_reg;
        motion_phase_next = motion_phase_reg;
        dir_next          = dir_reg;
        tick_en_next      = tick_en_reg;
        result.step_pulse = 1'b0;

        if (item.op)
        begin
            dir_next          = raw[MOVE_W-1];
            target_steps_next = target_new;
            half_target_next  = target_new[STEP_W-1:1];
            lim_latch_next    = max_speed_reg;
            acc_latch_next    = accel_rate_reg;
            motion_phase_next = PH_ACCEL;
            tick_en_next      = 1'b1;
        end
        else if (tick_en_reg)
        begin
            phase_acc_next    = phase_sum[ACC_BITS-1:0];
            result.step_pulse = pulse;
            taken_steps_next  = taken_inc;
            unique case (motion_phase_reg)
                PH_ACCEL:
                begin
                    if (cur_speed_reg >= lim_latch_reg)
                    begin
                        cur_speed_next    = lim_latch_reg;
                        motion_phase_next = PH_UNIFORM;
                    end
                    else
                    begin
                        ramp_steps_next = ramp_steps_reg + STEP_W'(pulse);
                        speed_acc_next  = speed_sum[ACC_BITS-1:0];
                        if (speed_up > NS_W'(SPEED_MAX))
                            cur_speed_next = SPEED_MAX;
                        else
                            cur_speed_next = speed_up[SPEED_W-1:0];
                        // midpoint check; zero-length move leaves on first step
                        if (half_target_reg != '0)
                        begin
                            if (taken_inc > {1'b0, half_target_reg})
                                motion_phase_next = PH_DECEL;
                        end
                        else if (taken_inc != '0)
                        begin
                            motion_phase_next = PH_DECEL;
                        end
                    end
                end
                PH_UNIFORM:
                begin
                    if (remaining < ramp_steps_reg)
                        motion_phase_next = PH_DECEL;
                end
                PH_DECEL:
                begin
                    if (taken_inc >= target_steps_reg)
                    begin
                        motion_phase_next = PH_IDLE;
                    end
                    else
                    begin
                        speed_acc_next = speed_sum[ACC_BITS-1:0];
                        if (speed_carry != '0 && NS_W'(cur_speed_reg) > NS_W'(speed_carry))
                            cur_speed_next = SPEED_W'(NS_W'(cur_speed_reg)
                                                      - NS_W'(speed_carry));
                    end
                end
                PH_IDLE:
                begin
                    // idle tick clears the move and stops the timer
                    lim_latch_next   = '0;
                    phase_acc_next   = '0;
                    speed_acc_next   = '0;
                    ramp_steps_next  = '0;
                    cur_speed_next   = '0;
                    taken_steps_next = '0;
                    tick_en_next     = 1'b0;
                end
            endcase
        end

        result.dir_ccw    = dir_next;
        result.phase_code = motion_phase_next;
        result.running    = tick_en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_latch_reg    <= '0;
            acc_latch_reg    <= '0;
            phase_acc_reg    <= '0;
            speed_acc_reg    <= '0;
            cur_speed_reg    <= '0;
            target_steps_reg <= '0;
            half_target_reg  <= '0;
            taken_steps_reg  <= '0;
            ramp_steps_reg   <= '0;
            motion_phase_reg <= PH_IDLE;
            dir_reg          <= 1'b0;
            tick_en_reg      <= 1'b0;
        end
        else if (item_accept)
        begin
            lim_latch_reg    <= lim_latch_next;
            acc_latch_reg    <= acc_latch_next;
            phase_acc_reg    <= phase_acc_next;
            speed_acc_reg    <= speed_acc_next;
            cur_speed_reg    <= cur_speed_next;
            target_steps_reg <= target_steps_next;
            half_target_reg  <= half_target_next;
            taken_steps_reg  <= taken_steps_next;
            ramp_steps_reg   <= ramp_steps_next;
            motion_phase_reg <= motion_phase_next;
            dir_reg          <= dir_next;
            tick_en_reg      <= tick_en_next;
        end
    end

endmodule

[src/srg_out_buf.sv]
// ----------------------------------------------------------------------------
// srg_out_buf
// Output register with one skid entry. Stall toward the input side is taken
// from the skid flag, so it is registered.
// ----------------------------------------------------------------------------
module srg_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  srg_pkg::out_t load_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_stall,
    output srg_pkg::out_t out_data
);
    import srg_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    out_t out_data_reg;
    out_t skid_data_reg;
    logic out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            // skid is empty whenever load can be high
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (!out_valid_reg || out_take)
                out_data_reg <= load_data;
            else
                skid_data_reg <= load_data;
        end
        else if (out_take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule

[src/spta_stepper_ramp_generator.sv]
// ----------------------------------------------------------------------------
// spta_stepper_ramp_generator
// Accumulator-based stepper ramp: start beats launch a move, tick beats
// advance the phase and speed accumulators and report step pulses.
// ----------------------------------------------------------------------------
// the result of an accepted beat is registered into the output buffer
// throughput: one beat per cycle while in_stall is low; all profile math
//   sits between the state registers and the two-entry output buffer
// in_stall rises only once the output buffer's skid entry is occupied
// reset clears all motion state and the output buffer; max_speed comes up
//   at 90000 and accel_rate at 10000
module spta_stepper_ramp_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  srg_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output srg_pkg::out_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srg_pkg::SPEED_W-1:0]   cfg_data
);
    import srg_pkg::*;

    logic in_accept;
    logic buf_full;
    out_t result;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    srg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (in_accept),
        .item        (in_data),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (result)
    );

    srg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .load_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[src/srg_checker.sv]
// ----------------------------------------------------------------------------
// srg_checker
// Port-level checks for the stepper ramp generator, bound to the top level.
// ----------------------------------------------------------------------------
module srg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input srg_pkg::out_t out_data
);
    import srg_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // stopped timer means idle phase
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.running |-> out_data.phase_code == PH_IDLE)
        else $error("timer stopped outside idle phase");

    // input stalls only behind a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && $past(out_valid && out_stall))
        else $error("input stalled without a blocked output");

    // an accepted beat reaches an empty output the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind spta_stepper_ramp_generator srg_checker u_srg_checker (.*);
